// ===== hdl/bvsm_pkg.sv =====
`default_nettype none
package bvsm_pkg;

   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int RAW_W      = 12;
   localparam int MV_W       = 16;
   localparam int TIME_W     = 32;
   localparam int LEVEL_W    = 3;
   localparam int COUNT_W    = 8;
   localparam int TREND_W    = 20;
   localparam int SCALE_W    = 27;            // divider (Q6.10) times ADC reference in mV
   localparam int PROD_W     = RAW_W + SCALE_W;
   localparam int MV_SHIFT   = 22;            // 4096 codes times 1024 divider scale

   // register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_DIVIDER  = 3'd0;
   localparam logic [2:0] REG_WARNING  = 3'd1;
   localparam logic [2:0] REG_LOW      = 3'd2;
   localparam logic [2:0] REG_CRITICAL = 3'd3;
   localparam logic [2:0] REG_ENABLE   = 3'd4;
   localparam logic [2:0] REG_CONFIRM  = 3'd5;
   localparam logic [2:0] REG_TREND_S  = 3'd6;
   localparam logic [2:0] REG_DROP     = 3'd7;

   // reported level codes
   localparam logic [LEVEL_W-1:0] LEVEL_OK       = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_WARNING  = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW      = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_ERROR    = 3'd4;

   localparam logic [MV_W-1:0]    DIVIDER_RESET  = 16'd11264;
   localparam logic [SCALE_W-1:0] SCALE_RESET    = 27'd20275200;
   localparam logic [MV_W-1:0]    WARNING_RESET  = 16'd10500;
   localparam logic [MV_W-1:0]    LOW_RESET      = 16'd9900;
   localparam logic [MV_W-1:0]    CRITICAL_RESET = 16'd9600;
   localparam logic [COUNT_W-1:0] CONFIRM_RESET  = 8'd3;
   localparam logic [TREND_W-1:0] TREND_S_RESET  = 20'd7200;
   localparam logic [MV_W-1:0]    DROP_RESET     = 16'd300;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [MV_W-1:0]    warning_mv;
      logic [MV_W-1:0]    low_mv;
      logic [MV_W-1:0]    critical_mv;
      logic               shutdown_enable;
      logic [COUNT_W-1:0] confirm_count;
      logic [TREND_W-1:0] trend_min_s;
      logic [MV_W-1:0]    trend_drop_mv;
   } cfg_type;

   typedef struct packed {
      logic [MV_W-1:0]    pack_mv;
      logic [LEVEL_W-1:0] level;
      logic               shutdown_trigger;
      logic [COUNT_W-1:0] critical_run;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/bvsm_csr.sv =====
`default_nettype none
module bvsm_csr
   import bvsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [MV_W-1:0]    divider_ff;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [MV_W-1:0]    warning_ff, low_ff, critical_ff, drop_ff;
   logic               enable_ff;
   logic [COUNT_W-1:0] confirm_ff;
   logic [TREND_W-1:0] trend_s_ff;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   // divider times 1800 (1024 + 512 + 256 + 8), kept ready for the multiplier
   assign scale_in = {1'b0, pwdata[15:0], 10'd0} + {2'b0, pwdata[15:0], 9'd0}
                   + {3'b0, pwdata[15:0], 8'd0} + {8'd0, pwdata[15:0], 3'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff  <= DIVIDER_RESET;
         scale_ff    <= SCALE_RESET;
         warning_ff  <= WARNING_RESET;
         low_ff      <= LOW_RESET;
         critical_ff <= CRITICAL_RESET;
         enable_ff   <= 1'b0;
         confirm_ff  <= CONFIRM_RESET;
         trend_s_ff  <= TREND_S_RESET;
         drop_ff     <= DROP_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DIVIDER: begin
               divider_ff <= pwdata[15:0];
               scale_ff   <= scale_in;
            end
            REG_WARNING:  warning_ff  <= pwdata[15:0];
            REG_LOW:      low_ff      <= pwdata[15:0];
            REG_CRITICAL: critical_ff <= pwdata[15:0];
            REG_ENABLE:   enable_ff   <= pwdata[0];
            REG_CONFIRM:  confirm_ff  <= pwdata[7:0];
            REG_TREND_S:  trend_s_ff  <= pwdata[19:0];
            REG_DROP:     drop_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DIVIDER:  prdata = {16'd0, divider_ff};
         REG_WARNING:  prdata = {16'd0, warning_ff};
         REG_LOW:      prdata = {16'd0, low_ff};
         REG_CRITICAL: prdata = {16'd0, critical_ff};
         REG_ENABLE:   prdata = {31'd0, enable_ff};
         REG_CONFIRM:  prdata = {24'd0, confirm_ff};
         REG_TREND_S:  prdata = {12'd0, trend_s_ff};
         REG_DROP:     prdata = {16'd0, drop_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.scale           = scale_ff;
   assign cfg.warning_mv      = warning_ff;
   assign cfg.low_mv          = low_ff;
   assign cfg.critical_mv     = critical_ff;
   assign cfg.shutdown_enable = enable_ff;
   assign cfg.confirm_count   = confirm_ff;
   assign cfg.trend_min_s     = trend_s_ff;
   assign cfg.trend_drop_mv   = drop_ff;

endmodule
`default_nettype wire

// ===== hdl/bvsm_scale.sv =====
`default_nettype none
module bvsm_scale
   import bvsm_pkg::*;
(
   input  wire logic [RAW_W-1:0]   raw,
   input  wire logic [SCALE_W-1:0] scale,
   output logic      [MV_W-1:0]    mv
);

   logic [PROD_W-1:0] product;

   assign product = PROD_W'(raw) * PROD_W'(scale);

   // quotient by 2^22 is 17 bits; saturate when the top bit is set
   assign mv = product[PROD_W-1] ? {MV_W{1'b1}} : product[PROD_W-2:MV_SHIFT];

endmodule
`default_nettype wire

// ===== hdl/bvsm_decide.sv =====
`default_nettype none
module bvsm_decide
   import bvsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              update,
   input  wire logic              sample_valid,
   input  wire logic [MV_W-1:0]   mv,
   input  wire logic [TIME_W-1:0] now_seconds,
   input  wire cfg_type           cfg,
   output result_type             result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               active_ff, active_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic [MV_W-1:0]    start_mv_ff, start_mv_in;
   logic               below_crit, below_low, below_warn;
   logic [TIME_W-1:0]  elapsed;
   logic [MV_W:0]      drop;
   logic               trend;
   logic [LEVEL_W-1:0] level;

   assign below_crit = mv <= cfg.critical_mv;
   assign below_low  = mv <= cfg.low_mv;
   assign below_warn = mv <= cfg.warning_mv;

   assign count_in = !below_crit ? '0
                   : (&count_ff) ? count_ff : count_ff + 1'b1;

   // latch time and voltage on the first sample of a warning episode
   assign active_in     = below_warn;
   assign start_time_in = !below_warn ? '0 : active_ff ? start_time_ff : now_seconds;
   assign start_mv_in   = !below_warn ? '0 : active_ff ? start_mv_ff : mv;

   assign elapsed = now_seconds - start_time_in;
   assign drop    = {1'b0, start_mv_in} - {1'b0, mv};
   assign trend   = below_warn && (elapsed >= TIME_W'(cfg.trend_min_s))
                    && !drop[MV_W] && (drop[MV_W-1:0] >= cfg.trend_drop_mv);

   always_comb begin
      if (!sample_valid)   level = LEVEL_ERROR;
      else if (below_crit) level = LEVEL_CRITICAL;
      else if (below_low)  level = LEVEL_LOW;
      else if (below_warn) level = LEVEL_WARNING;
      else                 level = LEVEL_OK;
   end

   assign result.pack_mv          = sample_valid ? mv : '0;
   assign result.level            = level;
   assign result.shutdown_trigger = sample_valid && cfg.shutdown_enable && below_crit
                                    && ((count_in >= cfg.confirm_count) || trend);
   assign result.critical_run     = sample_valid ? count_in : count_ff;

   // a failed ADC read leaves all state alone
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         active_ff     <= 1'b0;
         start_time_ff <= '0;
         start_mv_ff   <= '0;
      end else if (update && sample_valid) begin
         count_ff      <= count_in;
         active_ff     <= active_in;
         start_time_ff <= start_time_in;
         start_mv_ff   <= start_mv_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/battery_voltage_shutdown_monitor.sv =====
// Battery pack voltage monitor. Each transaction on the req_ channel carries one 12-bit ADC
// sample, a read-success flag and a seconds timestamp; the rsp_ channel returns one result per
// sample, in order: pack millivolts (raw * 1800 * divider / 2^22, saturated), level, shutdown
// trigger and the consecutive critical count. Throughput is one sample per clock while
// rsp_ready is high. An accepted req goes into the input register, which feeds the 12x27
// scaling multiply, the threshold compares and the critical counter and warning episode
// update, all combinational, into the result register that drives rsp_valid. When rsp_ready
// is low the result register holds, the input register fills behind it, and req_ready then
// drops until the result is taken. Thresholds and the divider are APB registers at byte
// offsets 0x00..0x1C; write them only while no sample is in flight.
`default_nettype none
module battery_voltage_shutdown_monitor
   import bvsm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [RAW_W-1:0]   req_sample_raw,
   input  wire logic               req_sample_valid,
   input  wire logic [TIME_W-1:0]  req_now_seconds,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [MV_W-1:0]    rsp_pack_mv,
   output logic      [LEVEL_W-1:0] rsp_level,
   output logic                    rsp_shutdown_trigger,
   output logic      [COUNT_W-1:0] rsp_critical_run,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [ADDR_W-1:0]  csr_paddr,
   input  wire logic [DATA_W-1:0]  csr_pwdata,
   output logic      [DATA_W-1:0]  csr_prdata,
   output logic                    csr_pready
);

   cfg_type            cfg;
   logic               s1_valid_ff, out_valid_ff;
   logic [RAW_W-1:0]   s1_raw_ff;
   logic               s1_sval_ff;
   logic [TIME_W-1:0]  s1_now_ff;
   logic [MV_W-1:0]    s1_mv;
   result_type         out_ff, out_in;
   logic               out_ready, s1_ready;
   logic               s1_move;

   bvsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_ready = s1_ready;
   assign s1_move   = s1_valid_ff && out_ready;

   bvsm_scale u_scale (
      .raw   (s1_raw_ff),
      .scale (cfg.scale),
      .mv    (s1_mv)
   );

   bvsm_decide u_decide (
      .clock        (clock),
      .reset        (reset),
      .update       (s1_move),
      .sample_valid (s1_sval_ff),
      .mv           (s1_mv),
      .now_seconds  (s1_now_ff),
      .cfg          (cfg),
      .result       (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (out_ready) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_raw_ff  <= req_sample_raw;
         s1_sval_ff <= req_sample_valid;
         s1_now_ff  <= req_now_seconds;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_pack_mv          = out_ff.pack_mv;
   assign rsp_level            = out_ff.level;
   assign rsp_shutdown_trigger = out_ff.shutdown_trigger;
   assign rsp_critical_run     = out_ff.critical_run;

endmodule
`default_nettype wire

// ===== hdl/bvsm_checker.sv =====
`default_nettype none
module bvsm_checker
   import bvsm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [MV_W-1:0]    rsp_pack_mv,
   input wire logic [LEVEL_W-1:0] rsp_level,
   input wire logic               rsp_shutdown_trigger,
   input wire logic [COUNT_W-1:0] rsp_critical_run
);

   // a shutdown is only ever raised on a critical sample
   a_trigger_critical : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shutdown_trigger |-> rsp_level == LEVEL_CRITICAL)
      else $error("shutdown raised on a non-critical sample");

   // a failed ADC read reports zero voltage and no shutdown
   a_error_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level == LEVEL_ERROR |-> rsp_pack_mv == '0 && !rsp_shutdown_trigger)
      else $error("ADC error transaction carries voltage or trigger");

   // a critical sample always leaves a nonzero run count
   a_critical_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level == LEVEL_CRITICAL |-> rsp_critical_run != '0)
      else $error("critical sample with zero run count");

   // any valid non-critical sample resets the run
   a_run_cleared : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_level == LEVEL_OK || rsp_level == LEVEL_WARNING
                    || rsp_level == LEVEL_LOW) |-> rsp_critical_run == '0)
      else $error("run count not cleared on non-critical sample");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pack_mv) && $stable(rsp_level)
                                  && $stable(rsp_shutdown_trigger) && $stable(rsp_critical_run))
      else $error("stalled response transaction changed");

endmodule

bind battery_voltage_shutdown_monitor bvsm_checker u_bvsm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_pack_mv          (rsp_pack_mv),
   .rsp_level            (rsp_level),
   .rsp_shutdown_trigger (rsp_shutdown_trigger),
   .rsp_critical_run     (rsp_critical_run)
);
`default_nettype wire
